/* rtl/rrhd_pkg.sv */
// Shared types and constants for the ray and bounded-plane depth test.
package rrhd_pkg;

   localparam int COORD_W = 21;
   localparam int VEC_W = 3 * COORD_W;
   localparam int RGB_W = 24;
   localparam int CSR_IDX_W = 3;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = COORD_W + DIFF_W;
   localparam int DOT_W = PROD_W + 1;
   localparam int MAG_W = DOT_W - 1;
   localparam int BM_W = MAG_W - 1;
   localparam int DMAG_W = COORD_W;
   localparam int SPLIT = 22;
   localparam int N_W = 64;
   localparam int QBITS = 23;
   localparam int Q_W = QBITS + 2;
   localparam int DIV_LAT = QBITS + 3;
   localparam int PE_W = Q_W + 1;
   localparam int TWO_W = PE_W + 1;
   localparam int SQ_W = 2 * DIFF_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
   localparam int COORD_MIN = -(2 ** (COORD_W - 1));
   localparam int B_MIN = 2;
   localparam int REQ_W = 192;
   localparam int RSP_W = 96;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER = 3'd0,
      CSR_SIZE   = 3'd1,
      CSR_NORMAL = 3'd2,
      CSR_COLOR  = 3'd3,
      CSR_CAMERA = 3'd4
   } csr_idx_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [VEC_W-1:0] vec_type;

   // Ray data that travels beside the dividers.
   typedef struct packed {
      logic    miss;
      vec_type o;
      vec_type nr;
      logic    empty;
   } side_type;

   typedef struct packed {
      logic                    valid;
      vec_type                 o;
      vec_type                 d;
      vec_type                 nr;
      logic                    empty;
      logic signed [DOT_W-1:0] a;
      logic signed [DOT_W-1:0] b;
   } dot_type;

   typedef struct packed {
      logic             valid;
      logic             is_hit;
      logic             replaced;
      vec_type          point;
      logic [RGB_W-1:0] rgb;
      logic             still_empty;
   } res_type;

   function automatic coord_type lane(input vec_type v, input int k);
      return coord_type'(v[COORD_W*k +: COORD_W]);
   endfunction

endpackage

/* rtl/rrhd_dot.sv */
// Three-stage pipeline for the two dot products n.(c-o) and n.d.
module rrhd_dot (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rrhd_pkg::vec_type o,
   input  rrhd_pkg::vec_type d,
   input  rrhd_pkg::vec_type nr,
   input  logic              empty,
   input  rrhd_pkg::vec_type center,
   input  rrhd_pkg::vec_type normal,
   output rrhd_pkg::dot_type dot
);
   import rrhd_pkg::*;

   logic                     vld_ff [3];
   vec_type                  o_ff [3];
   vec_type                  d_ff [3];
   vec_type                  nr_ff [3];
   logic                     empty_ff [3];
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [DIFF_W-1:0] diff_in [3];
   logic signed [PROD_W-1:0] pa_ff [3];
   logic signed [PROD_W-1:0] pb_ff [3];
   logic signed [PROD_W-1:0] pa_in [3];
   logic signed [PROD_W-1:0] pb_in [3];
   logic signed [DOT_W-1:0]  a_ff, b_ff, a_in, b_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = DIFF_W'(lane(center, k)) - DIFF_W'(lane(o, k));
         pa_in[k] = PROD_W'(lane(normal, k)) * PROD_W'(diff_ff[k]);
         pb_in[k] = PROD_W'(lane(normal, k)) * PROD_W'(lane(d_ff[0], k));
      end
      a_in = DOT_W'(pa_ff[0]) + DOT_W'(pa_ff[1]) + DOT_W'(pa_ff[2]);
      b_in = DOT_W'(pb_ff[0]) + DOT_W'(pb_ff[1]) + DOT_W'(pb_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 3; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff[0] <= o;
         d_ff[0] <= d;
         nr_ff[0] <= nr;
         empty_ff[0] <= empty;
         for (int s = 1; s < 3; s++) begin
            o_ff[s] <= o_ff[s-1];
            d_ff[s] <= d_ff[s-1];
            nr_ff[s] <= nr_ff[s-1];
            empty_ff[s] <= empty_ff[s-1];
         end
         diff_ff <= diff_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign dot = '{valid: vld_ff[2], o: o_ff[2], d: d_ff[2], nr: nr_ff[2],
                  empty: empty_ff[2], a: a_ff, b: b_ff};

endmodule

/* rtl/rrhd_div.sv */
// Pipelined scaled quotient (a*d)/b, truncated toward zero and clamped, one bit per stage.
module rrhd_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [rrhd_pkg::DOT_W-1:0] a,
   input  logic signed [rrhd_pkg::DOT_W-1:0] b,
   input  rrhd_pkg::coord_type               d,
   output logic signed [rrhd_pkg::Q_W-1:0]   q
);
   import rrhd_pkg::*;

   localparam int LO_W = SPLIT + DMAG_W;
   localparam int HI_W = MAG_W - SPLIT + DMAG_W;

   logic [MAG_W-1:0]  a_mag;
   logic [DMAG_W-1:0] d_mag;
   logic [LO_W-1:0]   ppl_ff;
   logic [HI_W-1:0]   pph_ff;
   logic [BM_W-1:0]   bm_ff [QBITS+2];
   logic              neg_ff [QBITS+3];
   logic [N_W-1:0]    n_ff;
   logic [N_W-1:0]    rem_ff [QBITS+1];
   logic [QBITS-1:0]  quo_ff [QBITS+1];
   logic              sat_ff [QBITS+1];
   logic              sat_in;
   logic [QBITS:0]    mag;

   always_comb begin
      a_mag = a[MAG_W-1:0];
      d_mag = d[COORD_W-1] ? DMAG_W'(-d) : DMAG_W'(d);
      // The quotient saturates once it reaches the clamp magnitude.
      sat_in = {1'b0, n_ff} >= {bm_ff[1], QBITS'(0)};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ppl_ff <= LO_W'(a_mag[SPLIT-1:0]) * LO_W'(d_mag);
         pph_ff <= HI_W'(a_mag[MAG_W-1:SPLIT]) * HI_W'(d_mag);
         bm_ff[0] <= b[BM_W-1:0];
         neg_ff[0] <= d[COORD_W-1];
         n_ff <= N_W'(ppl_ff) + (N_W'(pph_ff) << SPLIT);
         rem_ff[0] <= n_ff;
         quo_ff[0] <= '0;
         sat_ff[0] <= sat_in;
         for (int s = 1; s < QBITS + 2; s++) bm_ff[s] <= bm_ff[s-1];
         for (int s = 1; s < QBITS + 3; s++) neg_ff[s] <= neg_ff[s-1];
      end
   end

   for (genvar g = 0; g < QBITS; g++) begin : g_step
      localparam int BIT = QBITS - 1 - g;
      logic [N_W-1:0] sub;
      logic           take;
      assign sub = N_W'(bm_ff[g+2]) << BIT;
      assign take = rem_ff[g] >= sub;
      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[g+1] <= sat_ff[g];
            rem_ff[g+1] <= take ? rem_ff[g] - sub : rem_ff[g];
            quo_ff[g+1] <= quo_ff[g] | (take ? QBITS'(1) << BIT : QBITS'(0));
         end
      end
   end

   always_comb begin
      mag = sat_ff[QBITS] ? (QBITS+1)'(1) << QBITS : (QBITS+1)'(quo_ff[QBITS]);
      q = neg_ff[QBITS+2] ? -Q_W'(mag) : Q_W'(mag);
   end

endmodule

/* rtl/rrhd_back.sv */
// Box bound test, saturation, distance squares and the replace decision in three stages.
module rrhd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  rrhd_pkg::side_type              side,
   input  logic signed [rrhd_pkg::Q_W-1:0] q [3],
   input  rrhd_pkg::vec_type               center,
   input  rrhd_pkg::vec_type               size,
   input  rrhd_pkg::vec_type               camera,
   input  logic [rrhd_pkg::RGB_W-1:0]      color,
   output rrhd_pkg::res_type               res
);
   import rrhd_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff;
   logic                     hit1_ff, hit2_ff, hit_in;
   vec_type                  p1_ff, p2_ff, p_in;
   vec_type                  nr1_ff, nr2_ff;
   logic                     emp1_ff, emp2_ff;
   logic signed [SQ_W-1:0]   e2_ff [3];
   logic signed [SQ_W-1:0]   f2_ff [3];
   logic signed [SQ_W-1:0]   e2_in [3];
   logic signed [SQ_W-1:0]   f2_in [3];
   logic signed [PE_W-1:0]   pe;
   logic signed [TWO_W-1:0]  twop, lo, hi;
   logic signed [DIFF_W-1:0] e, f;
   logic signed [DIST_W-1:0] dh, dn;
   logic                     repl;
   res_type                  res_ff, res_in;

   always_comb begin
      hit_in = !side.miss;
      p_in = '0;
      for (int k = 0; k < 3; k++) begin
         pe = PE_W'(lane(side.o, k)) + PE_W'(q[k]);
         twop = TWO_W'(pe) + TWO_W'(pe);
         lo = TWO_W'(lane(center, k)) + TWO_W'(lane(center, k)) - TWO_W'(lane(size, k));
         hi = TWO_W'(lane(center, k)) + TWO_W'(lane(center, k)) + TWO_W'(lane(size, k));
         if (twop < lo || twop > hi) hit_in = 1'b0;
         if (pe > COORD_MAX) p_in[COORD_W*k +: COORD_W] = COORD_W'(COORD_MAX);
         else if (pe < COORD_MIN) p_in[COORD_W*k +: COORD_W] = COORD_W'(COORD_MIN);
         else p_in[COORD_W*k +: COORD_W] = COORD_W'(pe);
      end
      for (int k = 0; k < 3; k++) begin
         e = DIFF_W'(lane(p1_ff, k)) - DIFF_W'(lane(camera, k));
         f = DIFF_W'(lane(nr1_ff, k)) - DIFF_W'(lane(camera, k));
         e2_in[k] = SQ_W'(e) * SQ_W'(e);
         f2_in[k] = SQ_W'(f) * SQ_W'(f);
      end
      dh = DIST_W'(e2_ff[0]) + DIST_W'(e2_ff[1]) + DIST_W'(e2_ff[2]);
      dn = DIST_W'(f2_ff[0]) + DIST_W'(f2_ff[1]) + DIST_W'(f2_ff[2]);
      repl = hit2_ff && (emp2_ff || dh < dn);
      res_in.valid = v2_ff;
      res_in.is_hit = hit2_ff;
      res_in.replaced = repl;
      res_in.point = repl ? p2_ff : nr2_ff;
      res_in.rgb = repl ? color : '0;
      res_in.still_empty = !repl && emp2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit1_ff <= hit_in;
         p1_ff <= p_in;
         nr1_ff <= side.nr;
         emp1_ff <= side.empty;
         hit2_ff <= hit1_ff;
         p2_ff <= p1_ff;
         nr2_ff <= nr1_ff;
         emp2_ff <= emp1_ff;
         e2_ff <= e2_in;
         f2_ff <= f2_in;
         res_ff <= res_in;
      end
   end

   always_comb begin
      res = res_ff;
      res.valid = v3_ff;
   end

endmodule

/* rtl/ray_rectangle_hit_depth_test.sv */
// Pipeline stages from an accepted req beat to its rsp beat: 3 dot-product stages,
// 26 divider stages (product, sum, load, then one quotient bit each), 3 bound and depth stages.
// Throughput: one beat per cycle; the whole pipeline holds while rsp_tvalid waits on rsp_tready.
// Reset clears all valid bits and the configuration registers; no clearing pass is needed.
// Top level of the ray versus bounded-plane hit with nearest-point depth test.
module ray_rectangle_hit_depth_test (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, near_x, near_y, near_z, pixel_empty
   input  logic [rrhd_pkg::REQ_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // is_hit, replaced, point_x, point_y, point_z, red, green, blue, still_empty
   output logic [rrhd_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_we,
   input  logic [rrhd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrhd_pkg::VEC_W-1:0]        csr_wdata
);
   import rrhd_pkg::*;

   vec_type                center_ff, size_ff, normal_ff, camera_ff;
   logic [RGB_W-1:0]       color_ff;
   logic                   en;
   dot_type                dot;
   logic                   vld_ff [DIV_LAT];
   side_type               side_ff [DIV_LAT];
   side_type               side_in;
   logic signed [Q_W-1:0]  q [3];
   res_type                res;

   assign en = !res.valid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         size_ff <= '0;
         normal_ff <= '0;
         color_ff <= '0;
         camera_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_CENTER: center_ff <= csr_wdata;
            CSR_SIZE:   size_ff <= csr_wdata;
            CSR_NORMAL: normal_ff <= csr_wdata;
            CSR_COLOR:  color_ff <= csr_wdata[RGB_W-1:0];
            CSR_CAMERA: camera_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   rrhd_dot u_dot (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .o(req_tdata[VEC_W-1:0]), .d(req_tdata[2*VEC_W-1:VEC_W]),
      .nr(req_tdata[3*VEC_W-1:2*VEC_W]), .empty(req_tdata[3*VEC_W]),
      .center(center_ff), .normal(normal_ff), .dot(dot)
   );

   for (genvar k = 0; k < 3; k++) begin : g_div
      rrhd_div u_div (
         .clock(clock), .en(en), .a(dot.a), .b(dot.b),
         .d(lane(dot.d, k)), .q(q[k])
      );
   end

   // A grazing, back-facing or behind-origin ray never hits.
   assign side_in = '{miss: (dot.b < B_MIN) || (dot.a < 0), o: dot.o, nr: dot.nr,
                      empty: dot.empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_LAT; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= dot.valid;
         for (int s = 1; s < DIV_LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < DIV_LAT; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   rrhd_back u_back (
      .clock(clock), .reset(reset), .en(en), .in_valid(vld_ff[DIV_LAT-1]),
      .side(side_ff[DIV_LAT-1]), .q(q), .center(center_ff), .size(size_ff),
      .camera(camera_ff), .color(color_ff), .res(res)
   );

   assign rsp_tvalid = res.valid;
   assign rsp_tdata = {6'b0, res.still_empty, res.rgb[7:0], res.rgb[15:8], res.rgb[23:16],
                       res.point, res.replaced, res.is_hit};

endmodule

/* test/ray_rectangle_hit_depth_test_tb.sv */
// Testbench for the ray versus bounded-plane hit and nearest-point depth test.
module ray_rectangle_hit_depth_test_tb;
   import rrhd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS = 235;
   localparam int PHASE_COUNT = 8;

   // Packed so that origin lands in the lowest bits, as on req_tdata.
   typedef struct packed {
      logic    empty;
      vec_type nr;
      vec_type d;
      vec_type o;
   } ray_type;

   // Matches rsp_tdata from bit 0 up.
   typedef struct packed {
      logic       still_empty;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      vec_type    point;
      logic       replaced;
      logic       is_hit;
   } hit_type;

   typedef struct packed {
      logic    typed;
      hit_type want;
      ray_type ray;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VEC_W-1:0] csr_wdata;

   vec_type center_r, size_r, normal_r, camera_r;
   logic [RGB_W-1:0] color_r;

   hit_type pending_hits[$];
   row_type rows[$];
   int errors = 0;
   int cycles = 0;
   bit quiet_sender = 0;
   bit quiet_receiver = 0;

   ray_rectangle_hit_depth_test DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint coord_of(vec_type v, int k);
      coord_type c;
      c = v[COORD_W*k +: COORD_W];
      return longint'(c);
   endfunction

   function automatic vec_type pack3(longint x, longint y, longint z);
      return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic hit_type predict_hit(ray_type ry);
      longint o[3], d[3], nr[3], c[3], s[3], n[3], cm[3], p[3];
      longint a, b, q, pe, e, f, dh, dn;
      logic hit, repl;
      hit_type r;
      a = 0;
      b = 0;
      dh = 0;
      dn = 0;
      for (int k = 0; k < 3; k++) begin
         o[k] = coord_of(ry.o, k);
         d[k] = coord_of(ry.d, k);
         nr[k] = coord_of(ry.nr, k);
         c[k] = coord_of(center_r, k);
         s[k] = coord_of(size_r, k);
         n[k] = coord_of(normal_r, k);
         cm[k] = coord_of(camera_r, k);
         p[k] = 0;
         a += n[k] * (c[k] - o[k]);
         b += n[k] * d[k];
      end
      hit = 1'b0;
      repl = 1'b0;
      // A denominator of one raw unit or less is a grazing or back-facing ray.
      if (b >= B_MIN && a >= 0) begin
         hit = 1'b1;
         for (int k = 0; k < 3; k++) begin
            q = (a * d[k]) / b;
            pe = o[k] + clip(q, -(64'sd1 << 23), 64'sd1 << 23);
            if (2 * pe < 2 * c[k] - s[k] || 2 * pe > 2 * c[k] + s[k]) hit = 1'b0;
            p[k] = clip(pe, COORD_MIN, COORD_MAX);
         end
      end
      if (hit) begin
         for (int k = 0; k < 3; k++) begin
            e = p[k] - cm[k];
            f = nr[k] - cm[k];
            dh += e * e;
            dn += f * f;
         end
         repl = ry.empty || dh < dn;
      end
      r.is_hit = hit;
      r.replaced = repl;
      r.point = repl ? pack3(p[0], p[1], p[2]) : ry.nr;
      r.red = repl ? color_r[23:16] : 8'd0;
      r.green = repl ? color_r[15:8] : 8'd0;
      r.blue = repl ? color_r[7:0] : 8'd0;
      r.still_empty = repl ? 1'b0 : ry.empty;
      return r;
   endfunction

   function automatic ray_type mk_ray(longint ox, longint oy, longint oz, longint dx,
                                      longint dy, longint dz, longint nx, longint ny,
                                      longint nz, logic e);
      ray_type r;
      r.o = pack3(ox, oy, oz);
      r.d = pack3(dx, dy, dz);
      r.nr = pack3(nx, ny, nz);
      r.empty = e;
      return r;
   endfunction

   // Result of a ray that misses: everything passes through unchanged.
   function automatic hit_type miss_of(ray_type ry);
      hit_type r;
      r = '0;
      r.point = ry.nr;
      r.still_empty = ry.empty;
      return r;
   endfunction

   function automatic vec_type rand_vec();
      return VEC_W'({$urandom, $urandom});
   endfunction

   function automatic longint rand_signed(int span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly rays aimed at a point inside the box, the rest raw noise.
   function automatic ray_type gen_ray();
      ray_type r;
      longint half, pt[3], d[3], o[3], b;
      int t;
      if ($urandom_range(0, 9) < 3) begin
         r.o = rand_vec();
         r.d = rand_vec();
         r.nr = rand_vec();
         r.empty = 1'($urandom);
         return r;
      end
      b = 0;
      for (int k = 0; k < 3; k++) begin
         half = coord_of(size_r, k) / 2;
         if (half < 0) half = 0;
         if (half > 100000) half = 100000;
         pt[k] = coord_of(center_r, k) + rand_signed(int'(half));
         d[k] = rand_signed(2048);
         b += coord_of(normal_r, k) * d[k];
      end
      t = $urandom_range(1, 4);
      for (int k = 0; k < 3; k++) begin
         if (b <= 1) d[k] = -d[k];
         o[k] = pt[k] - t * d[k];
      end
      r.o = pack3(o[0], o[1], o[2]);
      r.d = pack3(d[0], d[1], d[2]);
      if ($urandom_range(0, 1))
         r.nr = pack3(pt[0] + rand_signed(4096), pt[1] + rand_signed(4096),
                      pt[2] + rand_signed(4096));
      else
         r.nr = rand_vec();
      r.empty = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      errors++;
   endtask

   task automatic write_regs(vec_type c, vec_type s, vec_type n, logic [RGB_W-1:0] rgb,
                             vec_type cam);
      csr_we <= 1'b1;
      csr_index <= CSR_CENTER;
      csr_wdata <= c;
      @(negedge clock);
      csr_index <= CSR_SIZE;
      csr_wdata <= s;
      @(negedge clock);
      csr_index <= CSR_NORMAL;
      csr_wdata <= n;
      @(negedge clock);
      csr_index <= CSR_COLOR;
      csr_wdata <= VEC_W'(rgb);
      @(negedge clock);
      csr_index <= CSR_CAMERA;
      csr_wdata <= cam;
      @(negedge clock);
      // An index past the last register must be dropped.
      csr_index <= CSR_IDX_W'(CSR_CAMERA) + 3'd1;
      csr_wdata <= rand_vec();
      @(negedge clock);
      csr_we <= 1'b0;
      center_r = c;
      size_r = s;
      normal_r = n;
      color_r = rgb;
      camera_r = cam;
   endtask

   task automatic drain();
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_ray(ray_type ry, bit typed, hit_type want);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, ry};
      do @(posedge clock); while (!req_tready);
      pending_hits.push_back(typed ? want : predict_hit(ry));
      @(negedge clock);
   endtask

   task automatic set_phase(int ph);
      case (ph % 5)
         0: write_regs(pack3(rand_signed(8192), rand_signed(8192), rand_signed(8192)),
                       pack3($urandom_range(0, 16384), $urandom_range(0, 16384),
                             $urandom_range(0, 16384)),
                       pack3(rand_signed(2048), rand_signed(2048), rand_signed(2048)),
                       RGB_W'($urandom), pack3(rand_signed(65536), rand_signed(65536),
                                               rand_signed(65536)));
         1: write_regs(pack3(COORD_MAX, COORD_MAX, COORD_MAX),
                       pack3(COORD_MAX, COORD_MAX, COORD_MAX),
                       pack3(COORD_MIN, COORD_MIN, COORD_MIN),
                       24'hFFFFFF, pack3(COORD_MIN, COORD_MIN, COORD_MIN));
         2: write_regs(pack3(rand_signed(4096), rand_signed(4096), rand_signed(4096)),
                       pack3(-rand_signed(0) - $urandom_range(1, 4096), 4096, 4096),
                       pack3(rand_signed(1024), rand_signed(1024), 1024),
                       RGB_W'($urandom), rand_vec());
         3: write_regs(rand_vec(), rand_vec(), rand_vec(), RGB_W'($urandom), rand_vec());
         default: write_regs(pack3(0, 0, 0), pack3(COORD_MAX, COORD_MAX, COORD_MAX),
                             pack3(rand_signed(64), rand_signed(64), rand_signed(64)),
                             24'h000000, pack3(0, 0, 0));
      endcase
   endtask

   initial begin
      ray_type ry;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_CENTER;
      csr_wdata <= '0;
      center_r = '0;
      size_r = '0;
      normal_r = '0;
      color_r = '0;
      camera_r = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset the normal is zero, so every ray misses.
      ry = mk_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      rows.push_back({1'b1, miss_of(ry), ry});
      ry = mk_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      rows.push_back({1'b1, miss_of(ry), ry});
      ry = mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
      rows.push_back({1'b1, miss_of(ry), ry});
      ry = mk_ray(0, 0, -4096, 0, 0, 1024, 5, -5, 7, 1'b1);
      rows.push_back({1'b1, miss_of(ry), ry});
      foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].want);
      req_tvalid <= 1'b0;
      drain();

      // Box of +/-2 units around the origin, normal mostly along z.
      write_regs(pack3(0, 0, 0), pack3(4096, 4096, 4096), pack3(1, 0, 1024),
                 24'hA5C33C, pack3(0, 0, -10240));
      rows.delete();
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, -4096, 0, 0, 1024, 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, -4096, 0, 0, -1024, 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, 0, 1, 0, 0, 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, 0, 2, 0, 0, 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, 4096, 0, 0, 1024, 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(100, -100, 0, 0, 5, 1024, 9, 9, 9, 1'b0)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(8192, 0, -4096, 0, 0, 1024, 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(2048, -2048, -4096, 0, 0, 1024,
                                                 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(2049, 0, -4096, 0, 0, 1024, 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, -4096, COORD_MAX, 0, 1,
                                                 0, 0, 0, 1'b1)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, -4096, 0, 0, 1024, 0, 0, -9000, 1'b0)});
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, -4096, 0, 0, 1024,
                                                 0, 0, COORD_MAX, 1'b0)});
      // Stored point at exactly the hit distance must be kept.
      rows.push_back({1'b0, hit_type'(0), mk_ray(0, 0, -4096, 0, 0, 1024, 0, 0, 0, 1'b0)});
      foreach (rows[i]) send_ray(rows[i].ray, 1'b0, rows[i].want);
      req_tvalid <= 1'b0;
      drain();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         set_phase(ph);
         quiet_sender = (ph % 3 == 2);
         quiet_receiver = (ph % 4 == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 1 && i == 100) begin
               req_tvalid <= 1'b0;
               while (pending_hits.size() != 0) @(negedge clock);
            end
            send_ray(gen_ray(), 1'b0, hit_type'(0));
         end
         req_tvalid <= 1'b0;
         drain();
      end

      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = quiet_receiver ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      hit_type got, want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(hit_type)-1:0];
         if (pending_hits.size() == 0) begin
            report("unexpected beat", longint'(got), 0);
         end else begin
            want = pending_hits.pop_front();
            if (got.is_hit !== want.is_hit) report("is_hit", got.is_hit, want.is_hit);
            if (got.replaced !== want.replaced) report("replaced", got.replaced, want.replaced);
            for (int k = 0; k < 3; k++)
               if (got.point[COORD_W*k +: COORD_W] !== want.point[COORD_W*k +: COORD_W])
                  report($sformatf("point lane %0d", k), got.point[COORD_W*k +: COORD_W],
                         want.point[COORD_W*k +: COORD_W]);
            if (got.red !== want.red) report("red", got.red, want.red);
            if (got.green !== want.green) report("green", got.green, want.green);
            if (got.blue !== want.blue) report("blue", got.blue, want.blue);
            if (got.still_empty !== want.still_empty)
               report("still_empty", got.still_empty, want.still_empty);
         end
      end
   end

endmodule

/* files.f */
rtl/rrhd_pkg.sv
rtl/rrhd_dot.sv
rtl/rrhd_div.sv
rtl/rrhd_back.sv
rtl/ray_rectangle_hit_depth_test.sv
test/ray_rectangle_hit_depth_test_tb.sv
